### rtl/zip_central_directory_walker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the central directory walker.
// ----------------------------------------------------------------------------
`ifndef ZIP_CENTRAL_DIRECTORY_WALKER_DEFINES_SVH
`define ZIP_CENTRAL_DIRECTORY_WALKER_DEFINES_SVH

// Property checked on clk, off while rst is high.
`define ZCDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on clk at every edge, reset included.
`define ZCDW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/zcdw_pkg.sv
// ----------------------------------------------------------------------------
// zcdw_pkg
// Types and constants shared by the central directory walker and its checker.
// ----------------------------------------------------------------------------
package zcdw_pkg;

  localparam logic [31:0] SIG_ENTRY       = 32'h02014b50;
  localparam logic [31:0] SIG_END         = 32'h06054b50;
  localparam logic [5:0]  SIG_LAST_POS    = 6'd3;
  localparam logic [5:0]  OFS_NAME_LEN    = 6'd28;
  localparam logic [5:0]  OFS_EXTRA_LEN   = 6'd30;
  localparam logic [5:0]  OFS_COMMENT_LEN = 6'd32;
  localparam logic [5:0]  HDR_LAST_POS    = 6'd45;
  localparam logic [15:0] ENTRY_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NAME   = 3'd0,
    KIND_NONAME = 3'd1,
    KIND_END    = 3'd2,
    KIND_BADSIG = 3'd3,
    KIND_TRUNC  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_byte;
    logic        name_end;
    logic [15:0] entry_index;
    logic        run_last;
  } result_t;

endpackage

### rtl/zip_central_directory_walker.sv
// ----------------------------------------------------------------------------
// zip_central_directory_walker
// Walks the records of a ZIP central directory one byte at a time.
// ----------------------------------------------------------------------------
// Bytes of the directory region arrive on s_axis, one per transaction, with
// s_axis_tlast on the final byte of the region. Each 46-byte record header is
// checked for the entry signature, its name, extra and comment lengths are
// captured, the name bytes go out on m_axis and the extra and comment bytes
// are dropped. An empty name gives one entry marker; the end signature gives
// a clean end, any other signature an error; a region that ends before the
// walk does gives a truncated marker after any other result of that byte.
// m_axis_tlast flags the last result of an input byte.
// An accepted byte is held in the input register; its results enter a
// two-slot output queue once it has room for all of them and show on
// m_axis from there. One byte is taken every cycle while the queue has
// room; a byte with two results (the final byte of a region) waits until
// the queue is empty. When m_axis stalls the queue fills and input stops
// after one more byte. Reset empties both stages and puts the walker at
// the start of a region; the end of every region also puts the walker
// back at the start.
// ----------------------------------------------------------------------------
module zip_central_directory_walker
  import zcdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // region_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] name_byte, [8] name_end,
                                      // [24:9] entry_index, [31:25] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // run_last
);

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // walker state
  phase_t      phase;
  logic [5:0]  header_position;
  logic [23:0] sig_shift;
  logic [15:0] name_length;
  logic [15:0] extra_length;
  logic [15:0] cmt_length;
  logic [16:0] remaining;
  logic [15:0] entry_count;

  phase_t      phase_next;
  logic [5:0]  header_position_next;
  logic [23:0] sig_shift_next;
  logic [15:0] name_length_next;
  logic [15:0] extra_length_next;
  logic [15:0] cmt_length_next;
  logic [16:0] remaining_next;
  logic [15:0] entry_count_next;

  logic [31:0] sig_full;
  logic [16:0] remain_dec;
  logic [16:0] skip_len;
  logic        finish;

  result_t     prim;
  result_t     trunc;
  result_t     res0;
  logic        prim_valid;
  logic        trunc_valid;
  logic [1:0]  n_res;
  logic        fire;

  // output queue
  result_t     q [2];
  result_t     q_next [2];
  logic [1:0]  q_cnt;
  logic [1:0]  q_cnt_mid;
  logic [1:0]  q_cnt_next;
  logic        pop;

  assign sig_full   = {s1_byte, sig_shift};
  assign remain_dec = (remaining != 17'd0) ? remaining - 17'd1 : 17'd0;
  assign skip_len   = {1'b0, extra_length} + {1'b0, cmt_length};

  // next state of the walk for the byte in the input register
  always_comb begin
    phase_next           = phase;
    header_position_next = header_position;
    sig_shift_next       = sig_shift;
    name_length_next     = name_length;
    extra_length_next    = extra_length;
    cmt_length_next      = cmt_length;
    remaining_next       = remaining;
    entry_count_next     = entry_count;
    finish               = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (header_position <= SIG_LAST_POS) begin
          sig_shift_next = sig_full[31:8];
        end
        if (header_position == SIG_LAST_POS) begin
          if (sig_full == SIG_ENTRY) begin
            header_position_next = header_position + 6'd1;
          end else begin
            phase_next = PH_DONE;
          end
        end else begin
          if (header_position == OFS_NAME_LEN) begin
            name_length_next = {8'h00, s1_byte};
          end else if (header_position == OFS_NAME_LEN + 6'd1) begin
            name_length_next = {s1_byte, name_length[7:0]};
          end else if (header_position == OFS_EXTRA_LEN) begin
            extra_length_next = {8'h00, s1_byte};
          end else if (header_position == OFS_EXTRA_LEN + 6'd1) begin
            extra_length_next = {s1_byte, extra_length[7:0]};
          end else if (header_position == OFS_COMMENT_LEN) begin
            cmt_length_next = {8'h00, s1_byte};
          end else if (header_position == OFS_COMMENT_LEN + 6'd1) begin
            cmt_length_next = {s1_byte, cmt_length[7:0]};
          end
          if (header_position >= HDR_LAST_POS) begin
            header_position_next = 6'd0;
            if (name_length != 16'd0) begin
              phase_next     = PH_NAME;
              remaining_next = {1'b0, name_length};
            end else begin
              finish = 1'b1;
            end
          end else begin
            header_position_next = header_position + 6'd1;
          end
        end
      end
      PH_NAME: begin
        if (remain_dec == 17'd0) begin
          finish = 1'b1;
        end else begin
          remaining_next = remain_dec;
        end
      end
      PH_SKIP: begin
        remaining_next = remain_dec;
        if (remain_dec == 17'd0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_DONE: begin
      end
    endcase
    // close the entry: count it and skip its extra and comment fields
    if (finish) begin
      entry_count_next = (entry_count == ENTRY_MAX) ? entry_count : entry_count + 16'd1;
      remaining_next   = skip_len;
      phase_next       = (skip_len != 17'd0) ? PH_SKIP : PH_HEADER;
    end
  end

  // results of the byte in the input register
  always_comb begin
    prim             = '0;
    prim.entry_index = entry_count;
    prim_valid       = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (header_position == SIG_LAST_POS) begin
          if (sig_full != SIG_ENTRY) begin
            prim_valid = 1'b1;
            prim.kind  = (sig_full == SIG_END) ? KIND_END : KIND_BADSIG;
          end
        end else if (header_position >= HDR_LAST_POS && name_length == 16'd0) begin
          prim_valid = 1'b1;
          prim.kind  = KIND_NONAME;
        end
      end
      PH_NAME: begin
        prim_valid     = 1'b1;
        prim.kind      = KIND_NAME;
        prim.name_byte = s1_byte;
        prim.name_end  = (remaining == 17'd1);
      end
      PH_SKIP, PH_DONE: begin
      end
    endcase
    trunc_valid       = s1_last && (phase_next != PH_DONE);
    trunc             = '0;
    trunc.kind        = KIND_TRUNC;
    trunc.entry_index = entry_count_next;
    trunc.run_last    = 1'b1;
    prim.run_last     = !trunc_valid;
    res0              = prim_valid ? prim : trunc;
    n_res             = {1'b0, prim_valid} + {1'b0, trunc_valid};
  end

  // advance only when the queue can take every result of this byte
  assign fire          = s1_valid && (n_res <= QUEUE_DEPTH - q_cnt);
  assign s_axis_tready = !s1_valid || fire;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_comb begin
    q_next    = q;
    q_cnt_mid = q_cnt;
    if (pop) begin
      q_next[0] = q[1];
      q_cnt_mid = q_cnt - 2'd1;
    end
    if (fire) begin
      if (n_res == 2'd2) begin
        q_next[0] = res0;
        q_next[1] = trunc;
      end else if (n_res == 2'd1) begin
        q_next[q_cnt_mid[0]] = res0;
      end
    end
    q_cnt_next = q_cnt_mid + (fire ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && s1_last)) begin
      phase           <= PH_HEADER;
      header_position <= 6'd0;
      sig_shift       <= 24'd0;
      name_length     <= 16'd0;
      extra_length    <= 16'd0;
      cmt_length      <= 16'd0;
      remaining       <= 17'd0;
      entry_count     <= 16'd0;
    end else if (fire) begin
      phase           <= phase_next;
      header_position <= header_position_next;
      sig_shift       <= sig_shift_next;
      name_length     <= name_length_next;
      extra_length    <= extra_length_next;
      cmt_length      <= cmt_length_next;
      remaining       <= remaining_next;
      entry_count     <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt_next;
    end
    q <= q_next;
  end

  assign m_axis_tvalid = (q_cnt != 2'd0);
  assign m_axis_tdata  = {7'd0, q[0].entry_index, q[0].name_end, q[0].name_byte};
  assign m_axis_tuser  = q[0].kind;
  assign m_axis_tlast  = q[0].run_last;

endmodule

### rtl/zcdw_checker.sv
// ----------------------------------------------------------------------------
// zcdw_checker
// Port-level checks on the result stream of the central directory walker.
// ----------------------------------------------------------------------------
`include "zip_central_directory_walker_defines.svh"

module zcdw_checker
  import zcdw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        stalled;
  logic        is_name;
  logic        terminal;
  logic [8:0]  name_bits;
  logic [35:0] out_word;

  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign is_name   = (m_axis_tuser == KIND_NAME);
  assign terminal  = (m_axis_tuser == KIND_END) || (m_axis_tuser == KIND_BADSIG) ||
                     (m_axis_tuser == KIND_TRUNC);
  assign name_bits = m_axis_tdata[8:0];
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // hold a stalled result
  `ZCDW_ASSERT(a_stall_hold, stalled |=> m_axis_tvalid && $stable(out_word), "stall not held")

  // only name results carry a name byte or a name end flag
  `ZCDW_ASSERT(a_name_fields, m_axis_tvalid && !is_name |-> name_bits == 9'd0, "name bits set")

  // end, error and truncation close the results of their byte
  `ZCDW_ASSERT(a_final_last, m_axis_tvalid && terminal |-> m_axis_tlast, "tlast missing")

  // queue is empty right after reset
  `ZCDW_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind zip_central_directory_walker zcdw_checker u_zcdw_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/zip_central_directory_walker_test.sv
// ----------------------------------------------------------------------------
// zip_central_directory_walker_test
// Self-checking bench for the ZIP central directory walker.
// ----------------------------------------------------------------------------
// Directory regions are built from record headers, names, skipped fields,
// end and bad signatures and raw noise, then streamed in one byte per
// transaction with bursty input timing. A byte-level walk model in the bench
// predicts every result. The output side stalls on its own random pattern,
// including one long hold-off. Each result is checked field by field.
// ----------------------------------------------------------------------------
module zip_central_directory_walker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import zcdw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 64;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_BYTES   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  zip_central_directory_walker DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walk model state
  phase_t      walk_phase;
  logic [5:0]  hdr_pos;
  logic [31:0] sig_window;
  logic [15:0] name_len;
  logic [15:0] extra_len;
  logic [15:0] comment_len;
  logic [16:0] remain;
  logic [15:0] entries_done;

  result_t     predicted_results[$];
  logic [7:0]  region_q[$];

  int fail_count   = 0;
  int bytes_sent   = 0;
  int results_seen = 0;
  int regions_sent = 0;
  int burst_left   = 0;
  bit steady       = 1'b0;
  bit hold_req     = 1'b0;
  int hold_cnt     = 0;
  int stretch_left = 0;
  int stall_pct    = 0;

  function automatic void clear_walk_state();
    walk_phase   = PH_HEADER;
    hdr_pos      = '0;
    sig_window   = '0;
    name_len     = '0;
    extra_len    = '0;
    comment_len  = '0;
    remain       = '0;
    entries_done = '0;
  endfunction

  function automatic void note_result(kind_t k, logic [7:0] b, logic e, logic [15:0] idx);
    result_t r;
    r.kind        = k;
    r.name_byte   = b;
    r.name_end    = e;
    r.entry_index = idx;
    r.run_last    = 1'b0;
    predicted_results = {predicted_results, r};
  endfunction

  function automatic void close_entry();
    if (entries_done != ENTRY_MAX) entries_done = entries_done + 16'd1;
    remain = {1'b0, extra_len} + {1'b0, comment_len};
    walk_phase = (remain != '0) ? PH_SKIP : PH_HEADER;
  endfunction

  // Expected results of one accepted byte, appended to predicted_results.
  function automatic void walk_predict(input logic [7:0] b, input logic last);
    int n_before;
    n_before = predicted_results.size();
    case (walk_phase)
      PH_HEADER: begin
        if (hdr_pos < 6'd4) sig_window = {b, sig_window[31:8]};
        if (hdr_pos == SIG_LAST_POS) begin
          if (sig_window == SIG_ENTRY) begin
            hdr_pos = 6'd4;
          end else if (sig_window == SIG_END) begin
            note_result(KIND_END, 8'h00, 1'b0, entries_done);
            walk_phase = PH_DONE;
          end else begin
            note_result(KIND_BADSIG, 8'h00, 1'b0, entries_done);
            walk_phase = PH_DONE;
          end
        end else begin
          case (hdr_pos)
            OFS_NAME_LEN:           name_len = {8'h00, b};
            OFS_NAME_LEN + 6'd1:    name_len[15:8] = b;
            OFS_EXTRA_LEN:          extra_len = {8'h00, b};
            OFS_EXTRA_LEN + 6'd1:   extra_len[15:8] = b;
            OFS_COMMENT_LEN:        comment_len = {8'h00, b};
            OFS_COMMENT_LEN + 6'd1: comment_len[15:8] = b;
            default: ;
          endcase
          if (hdr_pos >= HDR_LAST_POS) begin
            hdr_pos = '0;
            if (name_len != '0) begin
              walk_phase = PH_NAME;
              remain = {1'b0, name_len};
            end else begin
              note_result(KIND_NONAME, 8'h00, 1'b0, entries_done);
              close_entry();
            end
          end else begin
            hdr_pos = hdr_pos + 6'd1;
          end
        end
      end
      PH_NAME: begin
        note_result(KIND_NAME, b, remain == 17'd1, entries_done);
        if (remain != '0) remain = remain - 17'd1;
        if (remain == '0) close_entry();
      end
      PH_SKIP: begin
        if (remain != '0) remain = remain - 17'd1;
        if (remain == '0) walk_phase = PH_HEADER;
      end
      default: ;
    endcase
    if (last) begin
      // a region that stops before the walk ends is truncated
      if (walk_phase != PH_DONE) note_result(KIND_TRUNC, 8'h00, 1'b0, entries_done);
      clear_walk_state();
    end
    if (predicted_results.size() > n_before)
      predicted_results[predicted_results.size() - 1].run_last = 1'b1;
  endfunction

  // Region building
  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) region_q = {region_q, w[8*i +: 8]};
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) region_q = {region_q, 8'($urandom)};
  endtask

  task automatic add_header(input logic [15:0] nl, input logic [15:0] xl,
                            input logic [15:0] cl);
    logic [7:0] b;
    add_word(SIG_ENTRY);
    for (int i = 4; i <= HDR_LAST_POS; i++) begin
      b = 8'($urandom);
      if (i == OFS_NAME_LEN) b = nl[7:0];
      if (i == OFS_NAME_LEN + 1) b = nl[15:8];
      if (i == OFS_EXTRA_LEN) b = xl[7:0];
      if (i == OFS_EXTRA_LEN + 1) b = xl[15:8];
      if (i == OFS_COMMENT_LEN) b = cl[7:0];
      if (i == OFS_COMMENT_LEN + 1) b = cl[15:8];
      region_q = {region_q, b};
    end
  endtask

  task automatic add_record(input logic [15:0] nl, input logic [15:0] xl,
                            input logic [15:0] cl);
    add_header(nl, xl, cl);
    add_noise(int'(nl) + int'(xl) + int'(cl));
  endtask

  // Send one byte; bursts of random length with random gaps between them.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    bytes_sent++;
    walk_predict(b, last);
  endtask

  // Send the first count bytes of the built region, tlast on the final one.
  task automatic send_region(input int count);
    for (int i = 0; i < count; i++) send_byte(region_q[i], i == count - 1);
    region_q.delete();
    regions_sent++;
  endtask

  task automatic send_whole_region();
    send_region(region_q.size());
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (predicted_results.size() != 0);
  endtask

  task automatic test_signature_cases();
    add_word(SIG_END);
    send_whole_region();
    add_word(SIG_END);
    add_noise(3);
    send_whole_region();
    add_word(SIG_ENTRY ^ 32'h0000_0001);
    add_noise(2);
    send_whole_region();
    add_word(SIG_END ^ 32'h8000_0000);
    send_whole_region();
    region_q = {region_q, 8'h00};
    send_whole_region();
    region_q = {region_q, 8'hFF};
    send_whole_region();
    wait_drained();
  endtask

  task automatic test_record_shapes();
    add_record(16'd3, 16'd2, 16'd1);
    add_record(16'd0, 16'd0, 16'd0);
    add_word(SIG_END);
    send_whole_region();
    // empty name ending the region: entry marker plus truncation
    add_record(16'd0, 16'd0, 16'd0);
    send_whole_region();
    wait_drained();
  endtask

  task automatic test_truncated_regions();
    int cuts[2] = '{2, 30};
    foreach (cuts[i]) begin
      add_record(16'd4, 16'd3, 16'd3);
      add_word(SIG_END);
      send_region(cuts[i]);
    end
    wait_drained();
  endtask

  task automatic test_long_lengths();
    steady = 1'b1;
    // high name length bits, cut inside the name
    add_header(16'h8001, 16'hFFFF, 16'hFFFF);
    add_noise(6);
    send_whole_region();
    // extra plus comment needs the 17th count bit, cut inside the skip
    add_header(16'd1, 16'h8000, 16'h8000);
    add_noise(9);
    send_whole_region();
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    steady = 1'b1;
    add_record(16'd12, 16'd0, 16'd2);
    add_word(SIG_END);
    hold_req = 1'b1;
    send_whole_region();
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_regions();
    int start;
    int pick;
    int recs;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      steady = ($urandom_range(4) == 0);
      pick = $urandom_range(99);
      recs = (pick < 85) ? $urandom_range(1, 2) : $urandom_range(0, 1);
      for (int i = 0; i < recs; i++)
        add_record(($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 8)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
      if (pick < 70) begin
        add_word(SIG_END);
        add_noise($urandom_range(0, 3));
        send_whole_region();
      end else if (pick < 85) begin
        send_region($urandom_range(1, region_q.size()));
      end else begin
        if ($urandom_range(1) == 0) add_word(SIG_ENTRY ^ (32'd1 << $urandom_range(31)));
        else add_word($urandom);
        add_noise($urandom_range(0, 4));
        send_whole_region();
      end
    end
    steady = 1'b0;
    wait_drained();
  endtask

  // Output side: stall pattern by stretches, plus the requested hold-off.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
      m_ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 80);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stretch_left--;
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each output transaction with the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_valid && m_ready) begin
      results_seen++;
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d data=%h last=%b",
                 $time, m_user, m_data, m_last);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (m_user !== want.kind || m_data[7:0] !== want.name_byte ||
            m_data[8] !== want.name_end || m_data[24:9] !== want.entry_index ||
            m_data[31:25] !== 7'd0 || m_last !== want.run_last) begin
          $display("%0t: expected kind=%0d byte=%h end=%b index=%0d last=%b pad=0",
                   $time, want.kind, want.name_byte, want.name_end,
                   want.entry_index, want.run_last);
          $display("%0t: actual   kind=%0d byte=%h end=%b index=%0d last=%b pad=%h",
                   $time, m_user, m_data[7:0], m_data[8], m_data[24:9],
                   m_last, m_data[31:25]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    clear_walk_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_signature_cases();
    test_record_shapes();
    test_truncated_regions();
    test_long_lengths();
    test_output_holdoff();
    test_random_regions();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d regions, %0d bytes in, %0d results checked", regions_sent,
             bytes_sent, results_seen);
    $display("signatures, empty and long names, skips, truncation, output hold-off");
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/zcdw_pkg.sv
rtl/zip_central_directory_walker.sv
rtl/zcdw_checker.sv
tb/sv/zip_central_directory_walker_test.sv
